// ===== hw/rtl/ccs_pkg.sv =====
package ccs_pkg;

  localparam int FrameBytes = 7;

  localparam logic [1:0] HDR_ADDR    = 2'd0;
  localparam logic [1:0] HDR_FUNC    = 2'd1;
  localparam logic [1:0] HDR_PAYLOAD = 2'd2;

  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] ext_id;
    logic [3:0]  dlc;
    logic [7:0]  data0;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [7:0]  data3;
    logic [7:0]  data4;
    logic [7:0]  data5;
    logic [7:0]  data6;
    logic [7:0]  data7;
    logic        final_frame;
  } out_beat_t;

endpackage

// ===== hw/rtl/can_command_segmenter_top.sv =====
// CAN command segmenter.
// Input channel (in_valid/in_ready/in_beat): one command byte per beat,
// address first, then function code, then payload; last_byte marks the end.
// Output channel (out_valid/out_ready/out_beat): one CAN extended frame per
// beat, ext_id = {address, packet number}, data0 = function code, up to seven
// payload bytes with unused bytes zero, dlc = payload count + 1.
// A frame leaves once seven payload bytes are held, or on the last byte of a
// command with payload. Commands without payload produce no frame.
// Throughput: one input beat per cycle while the frame register is free,
// set by the single-pass packer between the input and frame registers.
// The completing beat passes the input register, then the frame register.
// Reset clears both valid flags and the packer state; the next beat is
// taken as an address. When out_ready is low with a frame waiting, the
// frame register holds, the input register keeps at most one beat, and once
// it holds one, in_ready stays low until the waiting frame leaves.
module can_command_segmenter_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ccs_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output ccs_pkg::out_beat_t out_beat
);

  logic               held_valid;
  ccs_pkg::in_beat_t  held_beat;
  logic               take;
  logic               push;
  logic               can_push;
  ccs_pkg::out_beat_t frame;

  ccs_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .take       (take),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  ccs_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_beat  (held_beat),
    .can_push   (can_push),
    .take       (take),
    .push       (push),
    .frame      (frame)
  );

  ccs_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .frame     (frame),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule

// ===== hw/rtl/ccs_in_reg.sv =====
module ccs_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ccs_pkg::in_beat_t in_beat,
  input  logic              take,
  output logic              held_valid,
  output ccs_pkg::in_beat_t held_beat
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_beat <= in_beat;
    end
  end

endmodule

// ===== hw/rtl/ccs_packer.sv =====
module ccs_packer (
  input  logic               clk,
  input  logic               rst,
  input  logic               held_valid,
  input  ccs_pkg::in_beat_t  held_beat,
  input  logic               can_push,
  output logic               take,
  output logic               push,
  output ccs_pkg::out_beat_t frame
);

  logic [1:0]      header_position;
  logic [7:0]      device_address;
  logic [7:0]      function_code;
  logic [6:0][7:0] payload_hold;
  logic [2:0]      fill_count;
  logic [7:0]      packet_number;

  logic            in_payload;
  logic [2:0]      count_next;
  logic [6:0][7:0] hold_next;
  logic            emit;

  assign in_payload = header_position[1];
  assign count_next = fill_count + 3'd1;
  assign take       = held_valid && can_push;

  always_comb begin
    hold_next = payload_hold;
    for (int i = 0; i < ccs_pkg::FrameBytes; i++) begin
      if (3'(i) == fill_count) begin
        hold_next[i] = held_beat.cmd_byte;
      end
    end
  end

  assign emit = in_payload &&
                (count_next == 3'(ccs_pkg::FrameBytes) || held_beat.last_byte);
  assign push = take && emit;

  always_comb begin
    frame.ext_id      = {device_address, packet_number};
    frame.dlc         = {1'b0, count_next} + 4'd1;
    frame.data0       = function_code;
    frame.data1       = hold_next[0];
    frame.data2       = hold_next[1];
    frame.data3       = hold_next[2];
    frame.data4       = hold_next[3];
    frame.data5       = hold_next[4];
    frame.data6       = hold_next[5];
    frame.data7       = hold_next[6];
    frame.final_frame = held_beat.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= ccs_pkg::HDR_ADDR;
      device_address  <= 8'd0;
      function_code   <= 8'd0;
      payload_hold    <= '0;
      fill_count      <= 3'd0;
      packet_number   <= 8'd0;
    end else if (take) begin
      if (held_beat.last_byte) begin
        // drop everything for the next command
        header_position <= ccs_pkg::HDR_ADDR;
        device_address  <= 8'd0;
        function_code   <= 8'd0;
        payload_hold    <= '0;
        fill_count      <= 3'd0;
        packet_number   <= 8'd0;
      end else if (header_position == ccs_pkg::HDR_ADDR) begin
        device_address  <= held_beat.cmd_byte;
        header_position <= ccs_pkg::HDR_FUNC;
      end else if (header_position == ccs_pkg::HDR_FUNC) begin
        function_code   <= held_beat.cmd_byte;
        header_position <= ccs_pkg::HDR_PAYLOAD;
      end else if (emit) begin
        payload_hold  <= '0;
        fill_count    <= 3'd0;
        packet_number <= packet_number + 8'd1;
      end else begin
        payload_hold <= hold_next;
        fill_count   <= count_next;
      end
    end
  end

endmodule

// ===== hw/rtl/ccs_out_reg.sv =====
module ccs_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ccs_pkg::out_beat_t frame,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output ccs_pkg::out_beat_t out_beat
);

  assign can_push = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_push) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (can_push && push) begin
      out_beat <= frame;
    end
  end

endmodule
